// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition holds whenever a trigger is true.
`define ASSERT_IMPLIES(lbl, trig, cond, msg) \
    `ASSERT_CLK(lbl, (trig) |-> (cond), msg)

`endif

// ----- rtl/lert_pkg.sv -----
`timescale 1ns / 1ps

package lert_pkg;

    localparam int SEQ_W        = 16;
    localparam int HIST_DEPTH   = 9;
    localparam int HIST_IDX_W   = 4;
    localparam int WIDX_W       = 3;
    localparam int WEIGHT_W     = 3;
    localparam int IN_TIME_W    = 32;
    localparam int RTT_W        = 24;
    localparam int RATE_OUT_W   = 25;
    // Weighted interval sums stay at or below 30 * 65535.
    localparam int ISUM_W       = 21;
    // Weight sums stay at or below 30.
    localparam int WSUM_W       = 5;
    localparam int DEN_W        = 21;

    typedef struct packed {
        logic                 cmd;
        logic [SEQ_W-1:0]     lost_seq;
        logic [SEQ_W-1:0]     before_seq;
        logic [IN_TIME_W-1:0] before_time;
        logic [SEQ_W-1:0]     after_seq;
        logic [IN_TIME_W-1:0] after_time;
        logic [RTT_W-1:0]     round_trip;
        logic [SEQ_W-1:0]     init_interval;
    } in_item_t;

    typedef struct packed {
        logic                  new_event;
        logic [SEQ_W-1:0]      loss_interval;
        logic [IN_TIME_W-1:0]  lost_time;
        logic [RATE_OUT_W-1:0] loss_rate;
        logic                  rate_rising;
    } out_item_t;

    // Averaging weights 1, 1, 1, 1, 0.8, 0.6, 0.4, 0.2 scaled by five.
    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [WIDX_W-1:0] k);
        logic [WEIGHT_W-1:0] w;
        unique case (k)
            3'd4:    w = 3'd4;
            3'd5:    w = 3'd3;
            3'd6:    w = 3'd2;
            3'd7:    w = 3'd1;
            default: w = 3'd5;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/lert_in_if.sv -----
`timescale 1ns / 1ps

interface lert_in_if;
    import lert_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/lert_out_if.sv -----
`timescale 1ns / 1ps

interface lert_out_if;
    import lert_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/loss_event_rate_tracker.sv -----
// Loss event rate tracker. Each input item either initializes the tracker or reports one
// lost packet, and yields exactly one result item. The block handles one item at a time
// and is not ready while it works. An init item goes straight to the output register. A
// loss report first interpolates the loss time with a multiply and a divide, unless a zero
// sequence gap skips the interpolation, and then checks whether it opens a new loss event.
// A report that opens a new event then sums the weighted interval history, compares the
// two averages and divides for the rate reciprocal. The work is done by one shared shift,
// add and subtract unit that produces one product or quotient bit per cycle, first for the
// loss time interpolation and then for the rate reciprocal, and by the pass over the
// interval history. A finished result waits in an output register; the next item is taken
// once that register has room for the current result.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module loss_event_rate_tracker #(
    parameter int RATE_FRACTION_BITS = 24,
    parameter int TIME_BITS          = 32
) (
    input logic        clk,
    input logic        rst_n,
    lert_in_if.sink    in_ch,
    lert_out_if.source out_ch
);
    import lert_pkg::*;

    localparam int RATE_W     = RATE_FRACTION_BITS + 1;
    localparam int PROD_W     = TIME_BITS + SEQ_W;
    localparam int NUM_W      = RATE_FRACTION_BITS + WSUM_W;
    localparam int DQ_W       = (PROD_W > NUM_W) ? PROD_W : NUM_W;
    localparam int DR_W       = DEN_W + 1;
    localparam int CNT_W      = $clog2(DQ_W + 1);
    localparam int CMP_W      = (TIME_BITS > RTT_W) ? TIME_BITS : RTT_W;
    localparam int PROD_SHIFT = DQ_W - PROD_W;
    localparam int NUM_SHIFT  = DQ_W - NUM_W;
    localparam int PCMP_W     = ISUM_W + WSUM_W;
    localparam logic [RATE_W-1:0] RATE_ONE = {1'b1, {RATE_FRACTION_BITS{1'b0}}};

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL    = 9'b000000010,
        S_IDIV   = 9'b000000100,
        S_EVAL   = 9'b000001000,
        S_SUM    = 9'b000010000,
        S_CMP1   = 9'b000100000,
        S_CMP2   = 9'b001000000,
        S_RDIV   = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic out_valid_reg, out_valid_next;
    logic [SEQ_W-1:0] hist_reg [HIST_DEPTH];
    logic [SEQ_W-1:0] hist_next [HIST_DEPTH];
    logic [SEQ_W-1:0] last_seq_reg, last_seq_next;
    logic [TIME_BITS-1:0] last_time_reg, last_time_next;
    logic [RATE_W-1:0] cur_rate_reg, cur_rate_next;
    logic [RATE_W-1:0] early_rate_reg, early_rate_next;

    logic [DQ_W-1:0] q_reg, q_next;
    logic [DR_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] divisor_reg, divisor_next;
    logic [SEQ_W-1:0] dl_reg, dl_next;
    logic [TIME_BITS-1:0] dt_reg, dt_next;
    logic [TIME_BITS-1:0] btime_reg, btime_next;
    logic [SEQ_W-1:0] lseq_reg, lseq_next;
    logic [RTT_W-1:0] rtt_reg, rtt_next;
    logic [TIME_BITS-1:0] lt_reg, lt_next;
    logic ev_reg, ev_next;
    logic [SEQ_W-1:0] iv_reg, iv_next;
    logic [ISUM_W-1:0] i0_reg, i0_next, i1_reg, i1_next;
    logic [WSUM_W-1:0] w0_reg, w0_next, w1_reg, w1_next;
    logic [PCMP_W-1:0] cmp_reg, cmp_next;
    out_item_t out_item_reg, out_item_next;

    in_item_t item;
    logic in_fire;
    logic [TIME_BITS-1:0] a_time, b_time, elapsed;
    logic [SEQ_W-1:0] ds, dl;
    logic new_ev;
    logic [DR_W-1:0] rem_sh, rem_step;
    logic div_ge;
    logic [DQ_W-1:0] q_div, q_mul;
    logic [HIST_IDX_W-1:0] sidx;
    logic [SEQ_W-1:0] h0, h1;
    logic [WEIGHT_W-1:0] wt;
    logic take1;
    logic [WSUM_W-1:0] num;
    logic [ISUM_W-1:0] den;
    logic shift_en;
    logic [SEQ_W-1:0] shift_val;

    assign item      = in_ch.payload;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign a_time    = TIME_BITS'(item.after_time);
    assign b_time    = TIME_BITS'(item.before_time);
    assign ds        = item.after_seq - item.before_seq;
    assign dl        = item.lost_seq - item.before_seq;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    // Shared unit: one restoring division step, or one shift-add multiply step.
    assign rem_sh   = {rem_reg[DR_W-2:0], q_reg[DQ_W-1]};
    assign div_ge   = (rem_sh >= {1'b0, divisor_reg});
    assign rem_step = div_ge ? (rem_sh - {1'b0, divisor_reg}) : rem_sh;
    assign q_div    = {q_reg[DQ_W-2:0], div_ge};
    assign q_mul    = (q_reg << 1)
                    + (dl_reg[SEQ_W-1] ? (DQ_W'(dt_reg) << PROD_SHIFT) : '0);

    // A new event needs a positive elapsed time longer than one round trip.
    assign elapsed = lt_reg - last_time_reg;
    assign new_ev  = !elapsed[TIME_BITS-1] && (CMP_W'(elapsed) > CMP_W'(rtt_reg));

    assign sidx = {1'b0, count_reg[WIDX_W-1:0]};
    assign h0   = hist_reg[sidx];
    assign h1   = hist_reg[sidx + HIST_IDX_W'(1)];
    assign wt   = weight_of(count_reg[WIDX_W-1:0]);

    // The shifted average wins when it is the only one defined or the larger one.
    assign take1 = (i1_reg != '0)
                && ((w0_reg == '0) || (cmp_reg > PCMP_W'(i0_reg) * PCMP_W'(w1_reg)));
    assign num   = take1 ? w1_reg : w0_reg;
    assign den   = take1 ? i1_reg : i0_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        last_seq_next   = last_seq_reg;
        last_time_next  = last_time_reg;
        cur_rate_next   = cur_rate_reg;
        early_rate_next = early_rate_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        dl_next         = dl_reg;
        dt_next         = dt_reg;
        btime_next      = btime_reg;
        lseq_next       = lseq_reg;
        rtt_next        = rtt_reg;
        lt_next         = lt_reg;
        ev_next         = ev_reg;
        iv_next         = iv_reg;
        i0_next         = i0_reg;
        i1_next         = i1_reg;
        w0_next         = w0_reg;
        w1_next         = w1_reg;
        cmp_next        = cmp_reg;
        out_item_next   = out_item_reg;
        shift_en        = 1'b0;
        shift_val       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (item.cmd)
                    begin
                        last_seq_next  = item.lost_seq;
                        last_time_next = a_time;
                        shift_en       = 1'b1;
                        shift_val      = item.init_interval;
                        lt_next        = a_time;
                        ev_next        = 1'b0;
                        iv_next        = '0;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        btime_next   = b_time;
                        lseq_next    = item.lost_seq;
                        rtt_next     = item.round_trip;
                        dl_next      = dl;
                        dt_next      = a_time - b_time;
                        divisor_next = DEN_W'(ds);
                        if (ds == '0)
                        begin
                            lt_next    = b_time;
                            state_next = S_EVAL;
                        end
                        else
                        begin
                            q_next     = '0;
                            count_next = CNT_W'(SEQ_W);
                            state_next = S_MUL;
                        end
                    end
                end
            end
            S_MUL:
            begin
                q_next     = q_mul;
                dl_next    = dl_reg << 1;
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    rem_next   = '0;
                    count_next = CNT_W'(PROD_W);
                    state_next = S_IDIV;
                end
            end
            S_IDIV:
            begin
                q_next     = q_div;
                rem_next   = rem_step;
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    lt_next    = btime_reg + q_div[TIME_BITS-1:0];
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (new_ev)
                begin
                    ev_next         = 1'b1;
                    iv_next         = lseq_reg - last_seq_reg;
                    last_seq_next   = lseq_reg;
                    last_time_next  = lt_reg;
                    shift_en        = 1'b1;
                    shift_val       = lseq_reg - last_seq_reg;
                    early_rate_next = cur_rate_reg;
                    i0_next         = '0;
                    i1_next         = '0;
                    w0_next         = '0;
                    w1_next         = '0;
                    count_next      = '0;
                    state_next      = S_SUM;
                end
                else
                begin
                    ev_next    = 1'b0;
                    iv_next    = '0;
                    state_next = S_FINISH;
                end
            end
            S_SUM:
            begin
                i0_next = i0_reg + ISUM_W'(h0) * ISUM_W'(wt);
                i1_next = i1_reg + ISUM_W'(h1) * ISUM_W'(wt);
                w0_next = w0_reg + ((h0 != '0) ? WSUM_W'(wt) : '0);
                w1_next = w1_reg + ((h1 != '0) ? WSUM_W'(wt) : '0);
                count_next = count_reg + CNT_W'(1);
                if (count_reg[WIDX_W-1:0] == '1)
                begin
                    state_next = S_CMP1;
                end
            end
            S_CMP1:
            begin
                cmp_next   = PCMP_W'(i1_reg) * PCMP_W'(w0_reg);
                state_next = S_CMP2;
            end
            S_CMP2:
            begin
                if (den == '0)
                begin
                    cur_rate_next = RATE_ONE;
                    state_next    = S_FINISH;
                end
                else
                begin
                    q_next       = (DQ_W'(num) << RATE_FRACTION_BITS) << NUM_SHIFT;
                    rem_next     = '0;
                    divisor_next = DEN_W'(den);
                    count_next   = CNT_W'(NUM_W);
                    state_next   = S_RDIV;
                end
            end
            S_RDIV:
            begin
                q_next     = q_div;
                rem_next   = rem_step;
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    cur_rate_next = q_div[RATE_W-1:0];
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.new_event     = ev_reg;
                    out_item_next.loss_interval = iv_reg;
                    out_item_next.lost_time     = IN_TIME_W'(lt_reg);
                    out_item_next.loss_rate     = RATE_OUT_W'(cur_rate_reg);
                    out_item_next.rate_rising   = (cur_rate_reg > early_rate_reg);
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            hist_next[k] = hist_reg[k];
        end
        if (shift_en)
        begin
            for (int k = 1; k < HIST_DEPTH; k++)
            begin
                hist_next[k] = hist_reg[k-1];
            end
            hist_next[0] = shift_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            last_seq_reg   <= '0;
            last_time_reg  <= '0;
            cur_rate_reg   <= '0;
            early_rate_reg <= '0;
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            last_seq_reg   <= last_seq_next;
            last_time_reg  <= last_time_next;
            cur_rate_reg   <= cur_rate_next;
            early_rate_reg <= early_rate_next;
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                hist_reg[k] <= hist_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        dl_reg       <= dl_next;
        dt_reg       <= dt_next;
        btime_reg    <= btime_next;
        lseq_reg     <= lseq_next;
        rtt_reg      <= rtt_next;
        lt_reg       <= lt_next;
        ev_reg       <= ev_next;
        iv_reg       <= iv_next;
        i0_reg       <= i0_next;
        i1_reg       <= i1_next;
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        cmp_reg      <= cmp_next;
        out_item_reg <= out_item_next;
    end

    `ASSERT_CLK(a_busy_after_accept, in_fire |=> (state_reg != S_IDLE), "idle after accept")
    `ASSERT_CLK(a_rate_bounded, cur_rate_reg <= RATE_ONE, "loss rate above one")
    `ASSERT_IMPLIES(a_rem_below_divisor, (state_reg == S_IDIV) || (state_reg == S_RDIV), rem_reg < {1'b0, divisor_reg}, "remainder too large")
    `ASSERT_IMPLIES(a_interval_needs_event, out_valid_reg && !out_item_reg.new_event, out_item_reg.loss_interval == '0, "stray interval")

endmodule
